/* rtl/wvm_pkg.sv */
package wvm_pkg;

	localparam int VOICES          = 8;
	localparam int TABLE_BITS      = 8;
	localparam int PHASE_FRAC_BITS = 16;

	localparam int PHASE_W     = TABLE_BITS + PHASE_FRAC_BITS;
	localparam int TABLE_DEPTH = 1 << TABLE_BITS;
	localparam int VIDX_W      = (VOICES > 1) ? $clog2(VOICES) : 1;

	// fixed port widths
	localparam int OP_W       = 3;
	localparam int VOICE_W    = 3;
	localparam int STEP_W     = 24;
	localparam int TIDX_W     = 8;
	localparam int WORD_W     = 16;
	localparam int GAIN_W     = 16;
	localparam int VOL_W      = 16;
	localparam int BEND_W     = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int SAMPLE_W   = 16;

	// widened forms used for masking and extension
	localparam int VEXT_W = (VIDX_W > VOICE_W) ? VIDX_W : VOICE_W;
	localparam int WIDE_W = (PHASE_W > STEP_W) ? PHASE_W : STEP_W;
	localparam int TEXT_W = (TABLE_BITS > TIDX_W) ? TABLE_BITS : TIDX_W;

	// mix arithmetic: gain * word fits 32 signed bits
	localparam int PROD_W      = 32;
	localparam int ACC_W       = PROD_W + ((VOICES > 1) ? $clog2(VOICES) : 0);
	localparam int LO_W        = 18;
	localparam int HI_W        = ACC_W - LO_W;
	localparam int MA_W        = ((HI_W > LO_W) ? HI_W : LO_W) + 1;
	localparam int MB_W        = VOL_W + 1;
	localparam int MUL_W       = MA_W + MB_W;
	localparam int TOT_W       = ACC_W + VOL_W + 2;
	localparam int SCALE_SHIFT = 32;
	localparam int S_W         = TOT_W - SCALE_SHIFT;

	typedef enum logic [OP_W-1:0] {
		OP_SAMPLE   = 3'd0,
		OP_ENV      = 3'd1,
		OP_NOTE_ON  = 3'd2,
		OP_NOTE_OFF = 3'd3,
		OP_TABLE_WR = 3'd4
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ATTACK_RATE   = 3'd0,
		CFG_ATTACK_PEAK   = 3'd1,
		CFG_DECAY_RATE    = 3'd2,
		CFG_SUSTAIN_LEVEL = 3'd3,
		CFG_RELEASE_RATE  = 3'd4,
		CFG_MASTER_VOLUME = 3'd5,
		CFG_PITCH_BEND    = 3'd6
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ENV_SILENT  = 5'b00001,
		ENV_ATTACK  = 5'b00010,
		ENV_DECAY   = 5'b00100,
		ENV_SUSTAIN = 5'b01000,
		ENV_RELEASE = 5'b10000
	} env_t;

	typedef struct packed {
		logic              acc_clr;
		logic              mix_issue;
		logic              env_step;
		logic              scale_lo;
		logic              scale_hi;
		logic              result_load;
		logic              note_on;
		logic              note_off;
		logic              tbl_wr;
		logic [VIDX_W-1:0] vidx;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

endpackage

/* rtl/wvm_ram.sv */
module wvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/wvm_ctrl.sv */
module wvm_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [wvm_pkg::OP_W-1:0]    op,
	input  wvm_pkg::stat_t              stat,
	output wvm_pkg::cmd_t               cmd
);

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b00000001,
		ST_MIX      = 8'b00000010,
		ST_DRAIN1   = 8'b00000100,
		ST_DRAIN2   = 8'b00001000,
		ST_SCALE_LO = 8'b00010000,
		ST_SCALE_HI = 8'b00100000,
		ST_RESULT   = 8'b01000000,
		ST_ENV      = 8'b10000000
	} state_t;

	state_t                       state_q, state_d;
	logic [wvm_pkg::VIDX_W-1:0]   cnt_q, cnt_d;
	logic                         accept;
	logic                         last_voice;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign last_voice = (cnt_q == wvm_pkg::VIDX_W'(wvm_pkg::VOICES - 1));

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.vidx = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (accept) begin
					unique case (wvm_pkg::op_t'(op))
						wvm_pkg::OP_SAMPLE: begin
							cmd.acc_clr = 1'b1;
							state_d     = ST_MIX;
						end
						wvm_pkg::OP_ENV:      state_d      = ST_ENV;
						wvm_pkg::OP_NOTE_ON:  cmd.note_on  = 1'b1;
						wvm_pkg::OP_NOTE_OFF: cmd.note_off = 1'b1;
						wvm_pkg::OP_TABLE_WR: cmd.tbl_wr   = 1'b1;
						default: ;
					endcase
				end
			end
			ST_MIX: begin
				cmd.mix_issue = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (last_voice) begin
					state_d = ST_DRAIN1;
				end
			end
			ST_DRAIN1:   state_d = ST_DRAIN2;
			ST_DRAIN2:   state_d = ST_SCALE_LO;
			ST_SCALE_LO: begin
				cmd.scale_lo = 1'b1;
				state_d      = ST_SCALE_HI;
			end
			ST_SCALE_HI: begin
				cmd.scale_hi = 1'b1;
				state_d      = ST_RESULT;
			end
			ST_RESULT: begin
				// hold until the output register can take the beat
				if (stat.out_free) begin
					cmd.result_load = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_ENV: begin
				cmd.env_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (last_voice) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

/* rtl/wvm_dp.sv */
module wvm_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wvm_pkg::cmd_t                       cmd,
	output wvm_pkg::stat_t                      stat,
	input  logic                                cfg_we,
	input  logic [wvm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wvm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [wvm_pkg::VOICE_W-1:0]         voice,
	input  logic [wvm_pkg::STEP_W-1:0]          phase_step,
	input  logic [wvm_pkg::TIDX_W-1:0]          table_index,
	input  logic signed [wvm_pkg::WORD_W-1:0]   table_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [wvm_pkg::SAMPLE_W-1:0] sample,
	output logic                                clipped
);

	localparam logic signed [wvm_pkg::S_W-1:0] SAT_HI = wvm_pkg::S_W'(32767);
	localparam logic signed [wvm_pkg::S_W-1:0] SAT_LO = wvm_pkg::S_W'(-32768);

	// configuration
	logic [wvm_pkg::GAIN_W-1:0]        attack_rate_q, attack_peak_q, decay_rate_q;
	logic [wvm_pkg::GAIN_W-1:0]        sustain_level_q, release_rate_q;
	logic [wvm_pkg::VOL_W-1:0]         master_volume_q;
	logic signed [wvm_pkg::BEND_W-1:0] pitch_bend_q;

	// per-voice state
	logic [wvm_pkg::PHASE_W-1:0] phase_q [wvm_pkg::VOICES];
	logic [wvm_pkg::PHASE_W-1:0] step_q  [wvm_pkg::VOICES];
	logic [wvm_pkg::GAIN_W-1:0]  gain_q  [wvm_pkg::VOICES];
	wvm_pkg::env_t               env_q   [wvm_pkg::VOICES];

	logic [wvm_pkg::VEXT_W-1:0]     voice_ext;
	logic                           voice_ok;
	logic [wvm_pkg::VIDX_W-1:0]     idx;
	logic [wvm_pkg::WIDE_W-1:0]     step_wide;
	logic signed [wvm_pkg::WIDE_W-1:0] bend_wide;
	logic [wvm_pkg::TEXT_W-1:0]     tidx_wide;
	logic [wvm_pkg::PHASE_W-1:0]    phase_new;
	logic [wvm_pkg::GAIN_W-1:0]     cur_gain;
	wvm_pkg::env_t                  cur_env;
	logic [wvm_pkg::GAIN_W-1:0]     env_gain;
	wvm_pkg::env_t                  env_next;
	logic signed [wvm_pkg::WORD_W-1:0] word;

	// mix pipeline
	logic                              mix_s1, mix_s2;
	logic [wvm_pkg::GAIN_W-1:0]        gain_s1;
	logic signed [wvm_pkg::MA_W-1:0]   mul_a;
	logic signed [wvm_pkg::MB_W-1:0]   mul_b;
	logic signed [wvm_pkg::MUL_W-1:0]  mul_q, lo_q;
	logic signed [wvm_pkg::ACC_W-1:0]  acc_q, mix_term;
	logic signed [wvm_pkg::TOT_W-1:0]  hi_ext, lo_ext, tot;
	logic signed [wvm_pkg::S_W-1:0]    s_full;
	logic signed [wvm_pkg::SAMPLE_W-1:0] sat_sample;
	logic                              sat_clip;

	logic                                out_valid_q;
	logic signed [wvm_pkg::SAMPLE_W-1:0] sample_q;
	logic                                clipped_q;

	assign voice_ext = wvm_pkg::VEXT_W'(voice);
	assign voice_ok  = (int'(voice) < wvm_pkg::VOICES);
	assign idx       = (cmd.note_on || cmd.note_off) ? voice_ext[wvm_pkg::VIDX_W-1:0] : cmd.vidx;
	assign step_wide = wvm_pkg::WIDE_W'(phase_step);
	assign bend_wide = pitch_bend_q;
	assign tidx_wide = wvm_pkg::TEXT_W'(table_index);

	assign cur_gain  = gain_q[idx];
	assign cur_env   = env_q[idx];
	assign phase_new = phase_q[idx] + step_q[idx] + bend_wide[wvm_pkg::PHASE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_rate_q   <= '0;
			attack_peak_q   <= '1;
			decay_rate_q    <= '0;
			sustain_level_q <= '0;
			release_rate_q  <= '0;
			master_volume_q <= '0;
			pitch_bend_q    <= '0;
		end else if (cfg_we) begin
			unique case (wvm_pkg::cfg_idx_t'(cfg_index))
				wvm_pkg::CFG_ATTACK_RATE:   attack_rate_q   <= cfg_data[wvm_pkg::GAIN_W-1:0];
				wvm_pkg::CFG_ATTACK_PEAK:   attack_peak_q   <= cfg_data[wvm_pkg::GAIN_W-1:0];
				wvm_pkg::CFG_DECAY_RATE:    decay_rate_q    <= cfg_data[wvm_pkg::GAIN_W-1:0];
				wvm_pkg::CFG_SUSTAIN_LEVEL: sustain_level_q <= cfg_data[wvm_pkg::GAIN_W-1:0];
				wvm_pkg::CFG_RELEASE_RATE:  release_rate_q  <= cfg_data[wvm_pkg::GAIN_W-1:0];
				wvm_pkg::CFG_MASTER_VOLUME: master_volume_q <= cfg_data[wvm_pkg::VOL_W-1:0];
				wvm_pkg::CFG_PITCH_BEND:    pitch_bend_q    <= cfg_data[wvm_pkg::BEND_W-1:0];
				default: ;
			endcase
		end
	end

	// one envelope step for the selected voice
	always_comb begin
		logic [wvm_pkg::GAIN_W:0] t_att, t_dec, t_rel;
		t_att    = {1'b0, cur_gain} + {1'b0, attack_rate_q};
		t_dec    = {1'b0, cur_gain} - {1'b0, decay_rate_q};
		t_rel    = {1'b0, cur_gain} - {1'b0, release_rate_q};
		env_gain = cur_gain;
		env_next = cur_env;
		unique case (cur_env)
			wvm_pkg::ENV_SILENT: env_gain = '0;
			wvm_pkg::ENV_ATTACK: begin
				if (t_att > {1'b0, attack_peak_q}) begin
					env_next = wvm_pkg::ENV_DECAY;
				end
				env_gain = t_att[wvm_pkg::GAIN_W] ? '1 : t_att[wvm_pkg::GAIN_W-1:0];
			end
			wvm_pkg::ENV_DECAY: begin
				// a borrow means the rate overshot: floor at zero
				env_gain = t_dec[wvm_pkg::GAIN_W] ? '0 : t_dec[wvm_pkg::GAIN_W-1:0];
				if (env_gain <= sustain_level_q) begin
					env_next = wvm_pkg::ENV_SUSTAIN;
				end
			end
			wvm_pkg::ENV_RELEASE: begin
				env_gain = t_rel[wvm_pkg::GAIN_W] ? '0 : t_rel[wvm_pkg::GAIN_W-1:0];
				if (env_gain == '0) begin
					env_next = wvm_pkg::ENV_SILENT;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wvm_pkg::VOICES; i++) begin
				phase_q[i] <= '0;
				step_q[i]  <= '0;
				gain_q[i]  <= '0;
				env_q[i]   <= wvm_pkg::ENV_SILENT;
			end
		end else begin
			if (cmd.mix_issue) begin
				phase_q[idx] <= phase_new;
			end
			if (cmd.env_step) begin
				gain_q[idx] <= env_gain;
				env_q[idx]  <= env_next;
			end
			if (cmd.note_on && voice_ok) begin
				step_q[idx] <= step_wide[wvm_pkg::PHASE_W-1:0];
				env_q[idx]  <= wvm_pkg::ENV_ATTACK;
			end
			if (cmd.note_off && voice_ok && cur_env != wvm_pkg::ENV_SILENT) begin
				env_q[idx] <= wvm_pkg::ENV_RELEASE;
			end
		end
	end

	wvm_ram #(
		.WIDTH(wvm_pkg::WORD_W),
		.DEPTH(wvm_pkg::TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (cmd.tbl_wr),
		.waddr(tidx_wide[wvm_pkg::TABLE_BITS-1:0]),
		.wdata(table_value),
		.raddr(phase_new[wvm_pkg::PHASE_W-1:wvm_pkg::PHASE_FRAC_BITS]),
		.rdata(word)
	);

	// shared multiplier: voice products, then the two halves of the volume scale
	always_comb begin
		if (mix_s1) begin
			mul_a = {{(wvm_pkg::MA_W - wvm_pkg::GAIN_W){1'b0}}, gain_s1};
			mul_b = {word[wvm_pkg::WORD_W-1], word};
		end else if (cmd.scale_lo) begin
			mul_a = {{(wvm_pkg::MA_W - wvm_pkg::LO_W){1'b0}}, acc_q[wvm_pkg::LO_W-1:0]};
			mul_b = {1'b0, master_volume_q};
		end else begin
			mul_a = {{(wvm_pkg::MA_W - wvm_pkg::HI_W){acc_q[wvm_pkg::ACC_W-1]}},
				acc_q[wvm_pkg::ACC_W-1:wvm_pkg::LO_W]};
			mul_b = {1'b0, master_volume_q};
		end
	end

	assign mix_term = wvm_pkg::ACC_W'(mul_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_s1 <= 1'b0;
			mix_s2 <= 1'b0;
		end else begin
			mix_s1 <= cmd.mix_issue;
			mix_s2 <= mix_s1;
		end
	end

	always_ff @(posedge clk) begin
		gain_s1 <= cur_gain;
		mul_q   <= mul_a * mul_b;
		if (cmd.scale_hi) begin
			lo_q <= mul_q;
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (mix_s2) begin
			acc_q <= acc_q + mix_term;
		end
	end

	// recombine the halves, floor by the arithmetic shift, then saturate
	assign hi_ext = wvm_pkg::TOT_W'(mul_q);
	assign lo_ext = wvm_pkg::TOT_W'(lo_q);
	assign tot    = (hi_ext <<< wvm_pkg::LO_W) + lo_ext;
	assign s_full = tot[wvm_pkg::TOT_W-1:wvm_pkg::SCALE_SHIFT];

	always_comb begin
		sat_clip   = 1'b0;
		sat_sample = s_full[wvm_pkg::SAMPLE_W-1:0];
		if (s_full > SAT_HI) begin
			sat_sample = SAT_HI[wvm_pkg::SAMPLE_W-1:0];
			sat_clip   = 1'b1;
		end else if (s_full < SAT_LO) begin
			sat_sample = SAT_LO[wvm_pkg::SAMPLE_W-1:0];
			sat_clip   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			sample_q  <= sat_sample;
			clipped_q <= sat_clip;
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign sample        = sample_q;
	assign clipped       = clipped_q;

endmodule

/* rtl/wavetable_voice_mixer_adsr_unit.sv */
// Polyphonic wavetable oscillator with per-voice ADSR envelopes. Note-on, note-off and
// table-write beats take effect in the cycle they are accepted. An envelope tick walks
// the voices one per cycle. A sample tick goes one voice per cycle through the phase
// update, the wavetable read and a single shared multiplier, then drains that pipeline,
// then runs the volume scale, which reuses the same multiplier in two halves, and the
// saturation, and is loaded into the output register once that register is free.
// The input takes a new beat as soon as the previous one has finished its work, also
// while a sample still waits at the output. The wavetable has no reset: reading an
// entry that was never written gives an undefined sample.
module wavetable_voice_mixer_adsr_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [wvm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wvm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [wvm_pkg::OP_W-1:0]            op,
	input  logic [wvm_pkg::VOICE_W-1:0]         voice,
	input  logic [wvm_pkg::STEP_W-1:0]          phase_step,
	input  logic [wvm_pkg::TIDX_W-1:0]          table_index,
	input  logic signed [wvm_pkg::WORD_W-1:0]   table_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [wvm_pkg::SAMPLE_W-1:0] sample,
	output logic                                clipped
);

	wvm_pkg::cmd_t  cmd;
	wvm_pkg::stat_t stat;

	wvm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op      (op),
		.stat    (stat),
		.cmd     (cmd)
	);

	wvm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.voice      (voice),
		.phase_step (phase_step),
		.table_index(table_index),
		.table_value(table_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample     (sample),
		.clipped    (clipped)
	);

endmodule

/* test/wvm_mix_checker.sv */
module wvm_mix_checker
	import wvm_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [OP_W-1:0]              op,
	input  logic [VOICE_W-1:0]           voice,
	input  logic [STEP_W-1:0]            phase_step,
	input  logic [TIDX_W-1:0]            table_index,
	input  logic signed [WORD_W-1:0]     table_value,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic signed [SAMPLE_W-1:0]   sample,
	input  logic                         clipped,
	output int                           backlog,
	output int                           errors
);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       clipped;
	} mix_out_t;

	localparam int     REPORT_CAP = 40;
	localparam int     GAIN_MAX   = (1 << GAIN_W) - 1;
	localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

	logic [GAIN_W-1:0]        atk_rate, atk_peak, dec_rate, sus_level, rel_rate;
	logic [VOL_W-1:0]         volume;
	logic signed [BEND_W-1:0] bend;

	logic [PHASE_W-1:0]       phase_acc [VOICES];
	logic [PHASE_W-1:0]       phase_inc [VOICES];
	logic [GAIN_W-1:0]        gain      [VOICES];
	env_t                     env_st    [VOICES];
	logic signed [WORD_W-1:0] wave      [TABLE_DEPTH];

	mix_out_t                 pending_mix [$];
	int                       fail_cnt = 0;

	assign errors = fail_cnt;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (fail_cnt < REPORT_CAP)
			$display("[%0t] mixer mismatch on %s: got %0d, want %0d", $time, what, got, want);
		fail_cnt++;
	endtask

	task automatic clear_model();
		atk_rate  = '0;
		atk_peak  = '1;
		dec_rate  = '0;
		sus_level = '0;
		rel_rate  = '0;
		volume    = '0;
		bend      = '0;
		for (int v = 0; v < VOICES; v++) begin
			phase_acc[v] = '0;
			phase_inc[v] = '0;
			gain[v]      = '0;
			env_st[v]    = ENV_SILENT;
		end
		pending_mix.delete();
	endtask

	task automatic apply_reg();
		case (cfg_index)
			CFG_ATTACK_RATE:   atk_rate  = cfg_data[GAIN_W-1:0];
			CFG_ATTACK_PEAK:   atk_peak  = cfg_data[GAIN_W-1:0];
			CFG_DECAY_RATE:    dec_rate  = cfg_data[GAIN_W-1:0];
			CFG_SUSTAIN_LEVEL: sus_level = cfg_data[GAIN_W-1:0];
			CFG_RELEASE_RATE:  rel_rate  = cfg_data[GAIN_W-1:0];
			CFG_MASTER_VOLUME: volume    = cfg_data[VOL_W-1:0];
			CFG_PITCH_BEND:    bend      = cfg_data[BEND_W-1:0];
			default: ;
		endcase
	endtask

	// advance every phase, then mix, scale by volume (floor) and saturate
	task automatic advance_and_mix(output mix_out_t res);
		longint             acc;
		longint             scaled;
		logic [PHASE_W-1:0] ph;
		acc = 0;
		for (int v = 0; v < VOICES; v++) begin
			ph           = phase_acc[v] + phase_inc[v] + PHASE_W'(longint'(bend));
			phase_acc[v] = ph;
			acc += longint'(gain[v]) * longint'(wave[ph[PHASE_W-1 -: TABLE_BITS]]);
		end
		scaled      = (acc * longint'(volume)) >>> SCALE_SHIFT;
		res.clipped = 1'b1;
		if (scaled > SAMPLE_MAX)
			res.sample = SAMPLE_W'(SAMPLE_MAX);
		else if (scaled < SAMPLE_MIN)
			res.sample = SAMPLE_W'(SAMPLE_MIN);
		else begin
			res.sample  = SAMPLE_W'(scaled);
			res.clipped = 1'b0;
		end
	endtask

	task automatic step_envelopes();
		int t;
		for (int v = 0; v < VOICES; v++) begin
			case (env_st[v])
				ENV_SILENT: gain[v] = '0;
				ENV_ATTACK: begin
					t = int'(gain[v]) + int'(atk_rate);
					if (t > int'(atk_peak))
						env_st[v] = ENV_DECAY;
					gain[v] = (t > GAIN_MAX) ? GAIN_W'(GAIN_MAX) : GAIN_W'(t);
				end
				ENV_DECAY: begin
					gain[v] = (gain[v] > dec_rate) ? gain[v] - dec_rate : '0;
					if (gain[v] <= sus_level)
						env_st[v] = ENV_SUSTAIN;
				end
				ENV_RELEASE: begin
					gain[v] = (gain[v] > rel_rate) ? gain[v] - rel_rate : '0;
					if (gain[v] == '0)
						env_st[v] = ENV_SILENT;
				end
				default: ;
			endcase
		end
	endtask

	task automatic take_beat();
		mix_out_t res;
		case (op)
			OP_SAMPLE: begin
				advance_and_mix(res);
				pending_mix.push_back(res);
			end
			OP_ENV: step_envelopes();
			OP_NOTE_ON: begin
				if (voice < VOICES) begin
					phase_inc[voice] = PHASE_W'(phase_step);
					env_st[voice]    = ENV_ATTACK;
				end
			end
			OP_NOTE_OFF: begin
				if (voice < VOICES && env_st[voice] != ENV_SILENT)
					env_st[voice] = ENV_RELEASE;
			end
			OP_TABLE_WR: wave[table_index[TABLE_BITS-1:0]] = table_value;
			default: ;
		endcase
	endtask

	task automatic check_mix();
		mix_out_t want;
		if (pending_mix.size() == 0) begin
			report_mismatch("unexpected sample beat", sample, 0);
		end else begin
			want = pending_mix.pop_front();
			if (sample !== want.sample)
				report_mismatch("sample", sample, want.sample);
			if (clipped !== want.clipped)
				report_mismatch("clipped", clipped, want.clipped);
		end
	endtask

	// the output beat always belongs to an older sample tick, so check it first
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
			backlog <= 0;
		end else begin
			if (cfg_we)
				apply_reg();
			if (out_valid && out_ready)
				check_mix();
			if (in_valid && in_ready)
				take_beat();
			backlog <= pending_mix.size();
		end
	end

endmodule

/* test/wavetable_voice_mixer_adsr_unit_tb.sv */
module wavetable_voice_mixer_adsr_unit_tb;
	import wvm_pkg::*;

	localparam int RESET_CYCLES = 12;
	localparam int SETTLE       = 24;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int PHASES       = 6;
	localparam int PHASE_BEATS  = 270;
	localparam int REG_COUNT    = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
	localparam logic [WORD_W-1:0]    WORD_MIN  = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic [WORD_W-1:0]    WORD_MAX  = {1'b0, {(WORD_W-1){1'b1}}};

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [CFG_IDX_W-1:0]         cfg_index;
	logic [CFG_DATA_W-1:0]        cfg_data;
	logic                         in_valid;
	logic                         in_ready;
	logic [OP_W-1:0]              op;
	logic [VOICE_W-1:0]           voice;
	logic [STEP_W-1:0]            phase_step;
	logic [TIDX_W-1:0]            table_index;
	logic signed [WORD_W-1:0]     table_value;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0]   sample;
	logic                         clipped;

	int                           backlog;
	int                           errors;
	int                           cycles  = 0;
	int                           rx_hold = 0;
	bit                           tx_steady;
	bit                           rx_steady;
	logic [CFG_DATA_W-1:0]        reg_val [REG_COUNT];

	wavetable_voice_mixer_adsr_unit DUT (.*);

	wvm_mix_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// receiver: alternate ready runs and stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_hold   <= 0;
		end else if (rx_steady) begin
			out_ready <= 1'b1;
			rx_hold   <= 0;
		end else if (rx_hold == 0) begin
			out_ready <= ~out_ready;
			rx_hold   <= out_ready ? idle_len() : $urandom_range(0, 12);
		end else begin
			rx_hold <= rx_hold - 1;
		end
	end

	task automatic send_beat(input logic [OP_W-1:0] b_op, input logic [VOICE_W-1:0] b_voice,
		input logic [STEP_W-1:0] b_step, input logic [TIDX_W-1:0] b_idx,
		input logic [WORD_W-1:0] b_val);
		int gap;
		gap = tx_steady ? 0 : idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= b_op;
		voice       <= b_voice;
		phase_step  <= b_step;
		table_index <= b_idx;
		table_value <= b_val;
		do @(posedge clk); while (in_ready !== 1'b1);
	endtask

	task automatic send_rand(input logic [OP_W-1:0] b_op);
		send_beat(b_op, VOICE_W'($urandom), STEP_W'($urandom), TIDX_W'($urandom),
			WORD_W'($urandom));
	endtask

	// drop valid, drain every sample, then give envelope work time to finish
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (backlog != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic program_regs();
		for (int k = 0; k < REG_COUNT; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(k);
			cfg_data  <= reg_val[k];
			@(posedge clk);
		end
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SPARE;
		cfg_data  <= CFG_DATA_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic pick_regs(input int ph);
		for (int k = 0; k < REG_COUNT; k++)
			reg_val[k] = CFG_DATA_W'($urandom);
		case (ph)
			0: begin
				for (int k = 0; k < REG_COUNT; k++)
					reg_val[k] = '0;
			end
			1: begin
				for (int k = 0; k < REG_COUNT; k++)
					reg_val[k] = '1;
				reg_val[CFG_PITCH_BEND] = {1'b0, {(BEND_W-1){1'b1}}};
			end
			2: reg_val[CFG_PITCH_BEND] = {1'b1, {(BEND_W-1){1'b0}}};
			3: begin
				// slow envelopes so decay and sustain last over many ticks
				reg_val[CFG_ATTACK_RATE][GAIN_W-1 -: 4]  = '0;
				reg_val[CFG_DECAY_RATE][GAIN_W-1 -: 4]   = '0;
				reg_val[CFG_RELEASE_RATE][GAIN_W-1 -: 4] = '0;
			end
			default: ;
		endcase
	endtask

	initial begin
		int n;
		int r;
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		op          <= OP_SAMPLE;
		voice       <= '0;
		phase_step  <= '0;
		table_index <= '0;
		table_value <= '0;
		rx_steady   <= 1'b0;
		tx_steady   = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_val[CFG_ATTACK_RATE]   = 24'h00ffff;
		reg_val[CFG_ATTACK_PEAK]   = 24'h00ffff;
		reg_val[CFG_DECAY_RATE]    = 24'h004000;
		reg_val[CFG_SUSTAIN_LEVEL] = 24'h002000;
		reg_val[CFG_RELEASE_RATE]  = 24'h00ffff;
		reg_val[CFG_MASTER_VOLUME] = 24'h00ffff;
		reg_val[CFG_PITCH_BEND]    = 24'h000000;
		program_regs();

		// every phase can land anywhere, so fill the whole table first
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_beat(OP_TABLE_WR, VOICE_W'($urandom), STEP_W'($urandom), TIDX_W'(i),
				(i == 0) ? WORD_MIN : (i == TABLE_DEPTH - 1) ? WORD_MAX : WORD_W'($urandom));

		// all voices parked on entry 0 at full gain: clip both ways
		for (int v = 0; v < VOICES; v++)
			send_beat(OP_NOTE_ON, VOICE_W'(v), '0, TIDX_W'($urandom), WORD_W'($urandom));
		send_rand(OP_ENV);
		send_rand(OP_SAMPLE);
		send_beat(OP_TABLE_WR, VOICE_W'($urandom), STEP_W'($urandom), '0, WORD_MAX);
		send_rand(OP_SAMPLE);
		send_rand(OP_ENV);
		send_rand(OP_ENV);
		send_beat(OP_NOTE_OFF, VOICE_W'(3), STEP_W'($urandom), TIDX_W'($urandom),
			WORD_W'($urandom));
		send_rand(OP_ENV);
		// note off on a silent voice, then retrigger with the largest step
		send_beat(OP_NOTE_OFF, VOICE_W'(3), STEP_W'($urandom), TIDX_W'($urandom),
			WORD_W'($urandom));
		send_beat(OP_NOTE_ON, VOICE_W'(VOICES - 1), '1, TIDX_W'($urandom), WORD_W'($urandom));
		send_rand(OP_SAMPLE);
		for (int k = OP_TABLE_WR + 1; k < (1 << OP_W); k++)
			send_rand(OP_W'(k));
		send_rand(OP_ENV);
		send_rand(OP_SAMPLE);
		send_beat(OP_NOTE_OFF, '0, STEP_W'($urandom), TIDX_W'($urandom), WORD_W'($urandom));
		send_rand(OP_SAMPLE);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			pick_regs(ph);
			program_regs();
			tx_steady = (ph == 3) || (ph == 5);
			rx_steady <= (ph == 4) || (ph == 5);
			n = 0;
			while (n < PHASE_BEATS) begin
				r = $urandom_range(0, 99);
				if (r < 35)
					send_rand(OP_SAMPLE);
				else if (r < 57)
					send_rand(OP_ENV);
				else if (r < 72)
					send_rand(OP_NOTE_ON);
				else if (r < 85)
					send_rand(OP_NOTE_OFF);
				else if (r < 95)
					send_rand(OP_TABLE_WR);
				else begin
					send_rand(OP_W'($urandom_range(OP_TABLE_WR + 1, (1 << OP_W) - 1)));
					continue;
				end
				n++;
			end
		end

		settle();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
